[src/swbp_pkg.sv]
package swbp_pkg;

	localparam logic [1:0] MODE_BITS8 = 2'd0;
	localparam logic [1:0] MODE_BITS7 = 2'd1;
	localparam logic [1:0] MODE_BITS9 = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic CMD_TX = 1'b0;
	localparam logic CMD_RX = 1'b1;

	localparam logic KIND_WORD = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	localparam logic [8:0] MASK_BITS9 = 9'h1FF;
	localparam logic [8:0] MASK_BITS8 = 9'h0FF;
	localparam logic [8:0] MASK_BITS7 = 9'h07F;

	// One queued item: one or two results of the same kind.
	typedef struct packed {
		logic       two;
		logic       kind;
		logic [8:0] v0;
		logic [8:0] v1;
	} entry_t;

	function automatic logic [3:0] word_bits(input logic [1:0] mode);
		logic [3:0] b;
		unique case (mode)
			MODE_BITS7: b = 4'd7;
			MODE_BITS9: b = 4'd9;
			default:    b = 4'd8;
		endcase
		return b;
	endfunction

	function automatic logic [8:0] word_mask(input logic [1:0] mode);
		logic [8:0] m;
		unique case (mode)
			MODE_BITS7: m = MASK_BITS7;
			MODE_BITS9: m = MASK_BITS9;
			default:    m = MASK_BITS8;
		endcase
		return m;
	endfunction

endpackage

[src/swbp_front.sv]
module swbp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_wr_data,
	input  logic                 accept,
	input  logic                 command,
	input  logic [8:0]           data,
	input  logic                 last,
	output logic                 enq,
	output swbp_pkg::entry_t     enq_entry
);

	logic [1:0]  mode_q;
	logic [15:0] tx_accum_q;
	logic [4:0]  tx_fill_q;
	logic [15:0] rx_accum_q;
	logic [4:0]  rx_fill_q;

	logic [3:0]  bits;
	logic [4:0]  bits5;
	logic [8:0]  mask;

	logic [15:0] tx_sum, tx_a1, tx_a2, tx_acc_end;
	logic [4:0]  tx_f0, tx_f1, tx_f2, tx_fill_end;
	logic        tx_n0, tx_n1, tx_pad;
	logic [8:0]  tx_w0, tx_w1, tx_wp;

	logic [15:0] rx_sum, rx_a1, rx_a2, rx_acc_end;
	logic [4:0]  rx_f0, rx_f1, rx_f2, rx_fill_end;
	logic        rx_n0, rx_n1;

	assign bits  = swbp_pkg::word_bits(mode_q);
	assign bits5 = {1'b0, bits};
	assign mask  = swbp_pkg::word_mask(mode_q);

	// Transmit: append eight bits, peel off up to two line words.
	assign tx_sum      = tx_accum_q | ({8'd0, data[7:0]} << tx_fill_q[3:0]);
	assign tx_f0       = tx_fill_q + 5'd8;
	assign tx_n0       = tx_f0 >= bits5;
	assign tx_a1       = tx_sum >> bits;
	assign tx_f1       = tx_f0 - bits5;
	assign tx_n1       = tx_n0 && (tx_f1 >= bits5);
	assign tx_a2       = tx_a1 >> bits;
	assign tx_f2       = tx_f1 - bits5;
	assign tx_acc_end  = tx_n1 ? tx_a2 : (tx_n0 ? tx_a1 : tx_sum);
	assign tx_fill_end = tx_n1 ? tx_f2 : (tx_n0 ? tx_f1 : tx_f0);
	assign tx_w0       = tx_sum[8:0] & mask;
	assign tx_w1       = tx_a1[8:0] & mask;
	assign tx_wp       = tx_acc_end[8:0] & mask;
	assign tx_pad      = last && (tx_fill_end != 5'd0) && !tx_n1;

	// Receive: append one line word, peel off up to two bytes.
	assign rx_sum      = rx_accum_q | ({7'd0, data & mask} << rx_fill_q[3:0]);
	assign rx_f0       = rx_fill_q + bits5;
	assign rx_n0       = rx_f0 >= 5'd8;
	assign rx_a1       = rx_sum >> 8;
	assign rx_f1       = rx_f0 - 5'd8;
	assign rx_n1       = rx_n0 && (rx_f1 >= 5'd8);
	assign rx_a2       = rx_a1 >> 8;
	assign rx_f2       = rx_f1 - 5'd8;
	assign rx_acc_end  = rx_n1 ? rx_a2 : (rx_n0 ? rx_a1 : rx_sum);
	assign rx_fill_end = rx_n1 ? rx_f2 : (rx_n0 ? rx_f1 : rx_f0);

	always_comb begin
		if (command == swbp_pkg::CMD_TX) begin
			enq            = accept && (tx_n0 || tx_pad);
			enq_entry.two  = tx_n0 && (tx_n1 || tx_pad);
			enq_entry.kind = swbp_pkg::KIND_WORD;
			enq_entry.v0   = tx_n0 ? tx_w0 : tx_wp;
			enq_entry.v1   = tx_n1 ? tx_w1 : tx_wp;
		end else begin
			enq            = accept && rx_n0;
			enq_entry.two  = rx_n1;
			enq_entry.kind = swbp_pkg::KIND_BYTE;
			enq_entry.v0   = {1'b0, rx_sum[7:0]};
			enq_entry.v1   = {1'b0, rx_a1[7:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= swbp_pkg::MODE_BITS8;
			tx_accum_q <= '0;
			tx_fill_q  <= '0;
			rx_accum_q <= '0;
			rx_fill_q  <= '0;
		end else if (cfg_wr_en) begin
			// A width change drops any partial word on both paths.
			mode_q     <= cfg_wr_data;
			tx_accum_q <= '0;
			tx_fill_q  <= '0;
			rx_accum_q <= '0;
			rx_fill_q  <= '0;
		end else if (accept) begin
			if (command == swbp_pkg::CMD_TX) begin
				tx_accum_q <= last ? 16'd0 : tx_acc_end;
				tx_fill_q  <= last ? 5'd0 : tx_fill_end;
			end else begin
				rx_accum_q <= last ? 16'd0 : rx_acc_end;
				rx_fill_q  <= last ? 5'd0 : rx_fill_end;
			end
		end
	end

endmodule

[src/swbp_queue.sv]
module swbp_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  swbp_pkg::entry_t     wr_entry,
	input  logic                 rd_en,
	output swbp_pkg::entry_t     rd_entry,
	output logic                 full,
	output logic                 empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	swbp_pkg::entry_t slots_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!full || rd_en))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("queue read while empty");

endmodule

[src/swbp_back.sv]
module swbp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  swbp_pkg::entry_t     q_entry,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic                 kind,
	output logic [8:0]           value,
	output logic                 run_last
);

	logic       out_valid_q;
	logic       sec_valid_q;
	logic [8:0] sec_value_q;
	logic       kind_q;
	logic [8:0] value_q;
	logic       run_last_q;
	logic       slot_free;
	logic       load_sec;

	assign slot_free = !out_valid_q || pop;
	assign load_sec  = slot_free && sec_valid_q;
	assign q_pop     = slot_free && !sec_valid_q && !q_empty;

	assign empty    = !out_valid_q;
	assign kind     = kind_q;
	assign value    = value_q;
	assign run_last = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_sec || q_pop || (out_valid_q && !pop);
			if (q_pop) begin
				sec_valid_q <= q_entry.two;
			end else if (load_sec) begin
				sec_valid_q <= 1'b0;
			end
		end
	end

	// The second result of an entry waits here until the first is taken.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q      <= q_entry.kind;
			value_q     <= q_entry.v0;
			run_last_q  <= !q_entry.two;
			sec_value_q <= q_entry.v1;
		end else if (load_sec) begin
			value_q    <= sec_value_q;
			run_last_q <= 1'b1;
		end
	end

	a_sec_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> (out_valid_q && !run_last_q))
		else $error("second result pending without a first one in front");

	a_sec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(sec_valid_q && pop) |=> (out_valid_q && run_last_q && !sec_valid_q))
		else $error("second result did not follow the first");

endmodule

[src/serial_word_bit_packer.sv]
// Byte/line-word gearbox for 8, 7 or 9 bit serial words, LSB first. A transmit
// item (command 0) adds one byte and yields each complete line word; with last
// set, leftover bits go out as one zero-padded word. A receive item (command 1)
// adds one line word and yields each complete byte; with last set, leftover
// bits are dropped. Writing cfg_wr_data (0: 8 bits, 1: 7 bits, 2: 9 bits, 3
// acts as 8) clears both paths. The front stage accepts one item per cycle
// while the result queue (QUEUE_DEPTH entries) has room; the output register
// delivers one result per cycle while pop is held, so an item that yields two
// results holds the output until both are popped, and the queue is not read
// meanwhile. With the output free, a result is written into a queue slot and
// then into the output register before it reaches the output ports.
module serial_word_bit_packer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       push,
	output logic       full,
	input  logic       command,
	input  logic [8:0] data,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic       kind,
	output logic [8:0] value,
	output logic       run_last
);

	logic             accept;
	logic             enq;
	swbp_pkg::entry_t enq_entry;
	swbp_pkg::entry_t q_entry;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;

	assign full   = q_full;
	assign accept = push && !q_full;

	swbp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.command     (command),
		.data        (data),
		.last        (last),
		.enq         (enq),
		.enq_entry   (enq_entry)
	);

	swbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (enq),
		.wr_entry (enq_entry),
		.rd_en    (q_pop),
		.rd_entry (q_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	swbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.kind     (kind),
		.value    (value),
		.run_last (run_last)
	);

endmodule
